FILE: rtl/rsgc_pkg.sv
package rsgc_pkg;

    // Default sizing
    localparam int              MAX_GROUP_LEN_DEF = 16;
    localparam longint unsigned MAX_GROUPS_DEF    = 64'd4194304;

    // Fixed field widths
    localparam int PIXEL_W   = 8;
    localparam int COUNT_W   = 23;
    localparam int MASK_W    = 16;
    localparam int GLEN_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    localparam int DIFF_W    = 9;
    localparam int NEG_W     = 10;

    // Register reset values
    localparam logic [MASK_W-1:0] FLIP_MASK_RST = 16'd6;
    localparam logic [GLEN_W-1:0] GROUP_LEN_RST = 5'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_MASK    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_LENGTH = 1'd1;

    // Class counter slots
    localparam int CLS_REG_POS = 0;
    localparam int CLS_SIN_POS = 1;
    localparam int CLS_REG_NEG = 2;
    localparam int CLS_SIN_NEG = 3;
    localparam int CLS_NUM     = 4;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last_pixel;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] regular_pos;
        logic [COUNT_W-1:0] singular_pos;
        logic [COUNT_W-1:0] regular_neg;
        logic [COUNT_W-1:0] singular_neg;
        logic [COUNT_W-1:0] groups_seen;
    } out_word_t;

    // Previous pixel values of the three views
    typedef struct packed {
        logic [PIXEL_W-1:0]      orig;
        logic [PIXEL_W-1:0]      flip_pos;
        logic signed [NEG_W-1:0] flip_neg;
    } prev_t;

    // Neighbor differences of the three views
    typedef struct packed {
        logic [DIFF_W-1:0] orig;
        logic [DIFF_W-1:0] flip_pos;
        logic [DIFF_W-1:0] flip_neg;
    } diff_t;

endpackage

FILE: rtl/rsgc_flip_diff.sv
module rsgc_flip_diff
(
    input  logic [rsgc_pkg::PIXEL_W-1:0] pixel,
    input  logic                         flip,
    input  rsgc_pkg::prev_t              prev,
    output rsgc_pkg::prev_t              cur,
    output rsgc_pkg::diff_t              diff
);

    logic [rsgc_pkg::PIXEL_W-1:0]        vp;
    logic signed [rsgc_pkg::NEG_W-1:0]   vn;
    logic signed [rsgc_pkg::NEG_W-1:0]   x_s;
    logic signed [rsgc_pkg::NEG_W:0]     dn;
    logic [rsgc_pkg::PIXEL_W-1:0]        d_orig;
    logic [rsgc_pkg::PIXEL_W-1:0]        d_pos;

    // Apply the LSB flip and the shift-by-one flip
    always_comb
    begin
        x_s = $signed({2'b00, pixel});
        if (flip)
        begin
            vp = pixel ^ 8'd1;
            vn = pixel[0] ? (x_s + 10'sd1) : (x_s - 10'sd1);
        end
        else
        begin
            vp = pixel;
            vn = x_s;
        end
    end

    // Take absolute neighbor differences
    always_comb
    begin
        d_orig = (pixel >= prev.orig) ? (pixel - prev.orig) : (prev.orig - pixel);
        d_pos  = (vp >= prev.flip_pos) ? (vp - prev.flip_pos) : (prev.flip_pos - vp);
        dn     = $signed({vn[rsgc_pkg::NEG_W-1], vn})
               - $signed({prev.flip_neg[rsgc_pkg::NEG_W-1], prev.flip_neg});
        diff.orig     = {1'b0, d_orig};
        diff.flip_pos = {1'b0, d_pos};
        diff.flip_neg = dn[rsgc_pkg::NEG_W] ? rsgc_pkg::DIFF_W'(-dn)
                                            : rsgc_pkg::DIFF_W'(dn);
        cur.orig      = pixel;
        cur.flip_pos  = vp;
        cur.flip_neg  = vn;
    end

endmodule

FILE: rtl/rs_group_classifier_unit.sv
// Regular/singular group counter. Pixels enter one word per clock and are cut
// into groups of group_length pixels (clamped to 2..MAX_GROUP_LEN); each group's
// smoothness is summed on the original pixels and under the positive and
// negative flip selected by flip_mask, and the group is counted as regular or
// singular for each flip (neither on equal sums). The block sustains one pixel
// per cycle: a pixel is registered in the input register, then the per-pixel
// update (three differences, three adds, four compares, counter bump) is written
// into the state registers. The word that carries last_pixel produces one result
// word with the four class counts and the group count, visible the cycle after it
// leaves the input register; counters then restart for the next image. A trailing
// partial group is dropped. Pixels without last_pixel keep flowing while a result
// word waits; a second last_pixel waits in the input register until the pending
// result is taken. Counters saturate at MAX_GROUPS.
module rs_group_classifier_unit
#(
    parameter int              MAX_GROUP_LEN = rsgc_pkg::MAX_GROUP_LEN_DEF,
    parameter longint unsigned MAX_GROUPS    = rsgc_pkg::MAX_GROUPS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rsgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsgc_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  rsgc_pkg::in_word_t             pixel_word,
    output logic                           result_valid,
    input  logic                           result_stall,
    output rsgc_pkg::out_word_t            result_word
);

    localparam int POS_W = $clog2(MAX_GROUP_LEN);
    localparam int LEN_W = $clog2(MAX_GROUP_LEN + 1);
    localparam int SUM_W = $clog2((MAX_GROUP_LEN - 1) * 257 + 1);
    localparam int CNT_W = $clog2(MAX_GROUPS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_GROUPS);

    // Configuration
    logic [rsgc_pkg::MASK_W-1:0] flip_mask_reg;
    logic [rsgc_pkg::GLEN_W-1:0] group_length_reg;

    // Input stage
    logic               in_valid_reg;
    rsgc_pkg::in_word_t in_word_reg;
    logic               advance;
    logic               accept;

    // Group state
    rsgc_pkg::prev_t    prev_reg;
    rsgc_pkg::prev_t    prev_next;
    rsgc_pkg::prev_t    cur;
    rsgc_pkg::diff_t    diff;
    logic [SUM_W-1:0]   sum_orig_reg, sum_pos_reg, sum_neg_reg;
    logic [SUM_W-1:0]   sum_orig_next, sum_pos_next, sum_neg_next;
    logic [SUM_W-1:0]   sum_orig_new, sum_pos_new, sum_neg_new;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   class_cnt_reg  [rsgc_pkg::CLS_NUM];
    logic [CNT_W-1:0]   class_cnt_next [rsgc_pkg::CLS_NUM];
    logic [CNT_W-1:0]   class_cnt_bump [rsgc_pkg::CLS_NUM];
    logic [CNT_W-1:0]   group_cnt_reg, group_cnt_next, group_cnt_bump;
    logic [LEN_W-1:0]   len_eff;
    logic               flip;
    logic               close;
    logic [rsgc_pkg::CLS_NUM-1:0] hit;

    // Result stage
    logic                result_valid_reg;
    rsgc_pkg::out_word_t result_word_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_mask_reg    <= rsgc_pkg::FLIP_MASK_RST;
            group_length_reg <= rsgc_pkg::GROUP_LEN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rsgc_pkg::REG_FLIP_MASK:    flip_mask_reg    <= cfg_data;
                rsgc_pkg::REG_GROUP_LENGTH: group_length_reg <= cfg_data[rsgc_pkg::GLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the input word unless it needs a busy result slot
    assign advance     = in_valid_reg
                       && (!in_word_reg.last_pixel || !result_valid_reg || !result_stall);
    assign pixel_stall = in_valid_reg && !advance;
    assign accept      = pixel_valid && !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_word_reg <= pixel_word;
    end

    // Clamp the group length and pick the flip for this position
    always_comb
    begin
        if (int'(group_length_reg) < 2)
            len_eff = LEN_W'(2);
        else if (int'(group_length_reg) > MAX_GROUP_LEN)
            len_eff = LEN_W'(MAX_GROUP_LEN);
        else
            len_eff = LEN_W'(group_length_reg);
        flip  = (int'(pos_reg) < rsgc_pkg::MASK_W) && flip_mask_reg[4'(pos_reg)];
        close = (int'(pos_reg) + 1) >= int'(len_eff);
    end

    rsgc_flip_diff u_flip_diff
    (
        .pixel (in_word_reg.pixel),
        .flip  (flip),
        .prev  (prev_reg),
        .cur   (cur),
        .diff  (diff)
    );

    // Accumulate sums, classify and clear closed groups, clear all at image end
    always_comb
    begin
        if (pos_reg != '0)
        begin
            sum_orig_new = sum_orig_reg + SUM_W'(diff.orig);
            sum_pos_new  = sum_pos_reg  + SUM_W'(diff.flip_pos);
            sum_neg_new  = sum_neg_reg  + SUM_W'(diff.flip_neg);
        end
        else
        begin
            sum_orig_new = sum_orig_reg;
            sum_pos_new  = sum_pos_reg;
            sum_neg_new  = sum_neg_reg;
        end

        hit[rsgc_pkg::CLS_REG_POS] = sum_orig_new < sum_pos_new;
        hit[rsgc_pkg::CLS_SIN_POS] = sum_orig_new > sum_pos_new;
        hit[rsgc_pkg::CLS_REG_NEG] = sum_orig_new < sum_neg_new;
        hit[rsgc_pkg::CLS_SIN_NEG] = sum_orig_new > sum_neg_new;

        for (int i = 0; i < rsgc_pkg::CLS_NUM; i++)
        begin
            if (close && hit[i] && (class_cnt_reg[i] < CNT_MAX))
                class_cnt_bump[i] = class_cnt_reg[i] + 1'b1;
            else
                class_cnt_bump[i] = class_cnt_reg[i];
        end
        if (close && (group_cnt_reg < CNT_MAX))
            group_cnt_bump = group_cnt_reg + 1'b1;
        else
            group_cnt_bump = group_cnt_reg;

        if (close || in_word_reg.last_pixel)
        begin
            prev_next     = '0;
            sum_orig_next = '0;
            sum_pos_next  = '0;
            sum_neg_next  = '0;
            pos_next      = '0;
        end
        else
        begin
            prev_next     = cur;
            sum_orig_next = sum_orig_new;
            sum_pos_next  = sum_pos_new;
            sum_neg_next  = sum_neg_new;
            pos_next      = pos_reg + 1'b1;
        end

        if (in_word_reg.last_pixel)
        begin
            for (int i = 0; i < rsgc_pkg::CLS_NUM; i++)
                class_cnt_next[i] = '0;
            group_cnt_next = '0;
        end
        else
        begin
            for (int i = 0; i < rsgc_pkg::CLS_NUM; i++)
                class_cnt_next[i] = class_cnt_bump[i];
            group_cnt_next = group_cnt_bump;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            sum_orig_reg  <= '0;
            sum_pos_reg   <= '0;
            sum_neg_reg   <= '0;
            pos_reg       <= '0;
            group_cnt_reg <= '0;
            for (int i = 0; i < rsgc_pkg::CLS_NUM; i++)
                class_cnt_reg[i] <= '0;
        end
        else if (advance)
        begin
            prev_reg      <= prev_next;
            sum_orig_reg  <= sum_orig_next;
            sum_pos_reg   <= sum_pos_next;
            sum_neg_reg   <= sum_neg_next;
            pos_reg       <= pos_next;
            group_cnt_reg <= group_cnt_next;
            for (int i = 0; i < rsgc_pkg::CLS_NUM; i++)
                class_cnt_reg[i] <= class_cnt_next[i];
        end
    end

    // Load the result word on the image's last pixel, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance && in_word_reg.last_pixel)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_word_reg.last_pixel)
        begin
            result_word_reg.regular_pos  <=
                rsgc_pkg::COUNT_W'(class_cnt_bump[rsgc_pkg::CLS_REG_POS]);
            result_word_reg.singular_pos <=
                rsgc_pkg::COUNT_W'(class_cnt_bump[rsgc_pkg::CLS_SIN_POS]);
            result_word_reg.regular_neg  <=
                rsgc_pkg::COUNT_W'(class_cnt_bump[rsgc_pkg::CLS_REG_NEG]);
            result_word_reg.singular_neg <=
                rsgc_pkg::COUNT_W'(class_cnt_bump[rsgc_pkg::CLS_SIN_NEG]);
            result_word_reg.groups_seen  <= rsgc_pkg::COUNT_W'(group_cnt_bump);
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    // A result word appears only after a last pixel was processed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(advance && in_word_reg.last_pixel))
        else $error("result word without a last pixel");

    // Counters restart after the last pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_word_reg.last_pixel) |=> (group_cnt_reg == '0 && pos_reg == '0))
        else $error("counters not cleared after last pixel");

    // Neither the regular-positive nor the singular-negative count exceeds the group count
    assert property (@(posedge clk) disable iff (!rst_n)
        (class_cnt_reg[rsgc_pkg::CLS_REG_POS] <= group_cnt_reg)
        && (class_cnt_reg[rsgc_pkg::CLS_SIN_NEG] <= group_cnt_reg))
        else $error("class count above group count");

endmodule
